>>> src/btlv_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btlv_pkg
// Types and constants shared by the BER-TLV stream parser.
// ----------------------------------------------------------------------------
package btlv_pkg;

    localparam int MAX_TAG_EXT_BYTES_DEF = 4;
    localparam int MAX_LENGTH_BYTES_DEF  = 4;

    localparam logic [4:0] TAG_ESC      = 5'h1F;
    localparam int         TAG_W        = 28;
    localparam int         LEN_W        = 32;

    typedef enum logic [1:0] {
        KIND_HEADER    = 2'd0,
        KIND_VALUE     = 2'd1,
        KIND_TRUNCATED = 2'd2,
        KIND_OVERSIZED = 2'd3
    } kind_t;

    typedef enum logic [4:0] {
        PH_TAG    = 5'b00001,
        PH_TAGEXT = 5'b00010,
        PH_LEN    = 5'b00100,
        PH_LENEXT = 5'b01000,
        PH_VALUE  = 5'b10000
    } phase_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_buffer;
    } in_beat_t;

    typedef struct packed {
        logic [1:0]       kind;
        logic [7:0]       first_tag_byte;
        logic [TAG_W-1:0] tag_number;
        logic             is_constructed;
        logic [LEN_W-1:0] value_length;
        logic [7:0]       value_byte;
        logic             last_value;
        logic             run_last;
    } out_beat_t;

endpackage

>>> src/ber_tlv_stream_parser_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ber_tlv_stream_parser_top
// Byte-wide BER-TLV parser: tags, short/long lengths, value bytes, errors.
// ----------------------------------------------------------------------------
// One byte is taken per beat and the parser state advances in the same cycle,
// so a byte can be accepted on every clock while s_ready is high. Each byte
// yields zero, one or two result beats (two only when the buffer ends inside
// an element), which are written to a four-entry result queue; the queue parts
// the two sides, and s_ready drops only while fewer than two entries are free.
// With m_ready held high the block sustains one byte per cycle.
// Constructed elements are not tracked on a stack: their children are parsed
// inline as ordinary elements.
// ----------------------------------------------------------------------------
module ber_tlv_stream_parser_top #(
    parameter int MAX_TAG_EXT_BYTES = btlv_pkg::MAX_TAG_EXT_BYTES_DEF,
    parameter int MAX_LENGTH_BYTES  = btlv_pkg::MAX_LENGTH_BYTES_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  btlv_pkg::in_beat_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output btlv_pkg::out_beat_t m_data
);

    localparam int TEW   = $clog2(MAX_TAG_EXT_BYTES + 1);
    localparam int LBW   = $clog2(MAX_LENGTH_BYTES + 1);
    localparam int DEPTH = 4;
    localparam int PW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);

    localparam logic [TEW-1:0] TAG_EXT_MAX = TEW'(MAX_TAG_EXT_BYTES);
    localparam logic [6:0]     LEN_CNT_MAX = 7'(MAX_LENGTH_BYTES);
    localparam logic [CW-1:0]  FILL_LIMIT  = CW'(DEPTH - 2);

    btlv_pkg::phase_t              phase_reg, phase_next;
    logic [7:0]                    held_tag_reg, held_tag_next;
    logic [btlv_pkg::TAG_W-1:0]    tag_acc_reg, tag_acc_next;
    logic [TEW-1:0]                tag_ext_cnt_reg, tag_ext_cnt_next;
    logic                          cons_reg, cons_next;
    logic [btlv_pkg::LEN_W-1:0]    len_acc_reg, len_acc_next;
    logic [LBW-1:0]                len_left_reg, len_left_next;
    logic [btlv_pkg::LEN_W-1:0]    val_left_reg, val_left_next;

    btlv_pkg::out_beat_t           fifo_reg [DEPTH];
    logic [PW-1:0]                 wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]                 count_reg, count_next;

    logic                          in_fire, out_fire;
    logic [7:0]                    b;
    logic                          do_hdr;
    logic                          r0_vld;
    logic                          trunc;
    btlv_pkg::out_beat_t           r0, rt, beat_a, beat_b;
    logic [1:0]                    n_push;
    logic [LBW-1:0]                len_left_dec;
    logic [btlv_pkg::LEN_W-1:0]    val_left_dec;

    assign in_fire  = s_valid && s_ready;
    assign out_fire = m_valid && m_ready;
    assign b        = s_data.data_byte;

    assign len_left_dec = len_left_reg - LBW'(1);
    assign val_left_dec = val_left_reg - btlv_pkg::LEN_W'(1);

    always_comb begin
        phase_next       = phase_reg;
        held_tag_next    = held_tag_reg;
        tag_acc_next     = tag_acc_reg;
        tag_ext_cnt_next = tag_ext_cnt_reg;
        cons_next        = cons_reg;
        len_acc_next     = len_acc_reg;
        len_left_next    = len_left_reg;
        val_left_next    = val_left_reg;
        do_hdr           = 1'b0;
        r0_vld           = 1'b0;
        r0               = '0;
        rt               = '0;
        rt.kind          = btlv_pkg::KIND_TRUNCATED;

        case (phase_reg)
            btlv_pkg::PH_TAG: begin
                held_tag_next    = b;
                cons_next        = b[5];
                tag_ext_cnt_next = '0;
                if (b[4:0] == btlv_pkg::TAG_ESC) begin
                    tag_acc_next = '0;
                    phase_next   = btlv_pkg::PH_TAGEXT;
                end else begin
                    tag_acc_next = {23'd0, b[4:0]};
                    phase_next   = btlv_pkg::PH_LEN;
                end
            end
            btlv_pkg::PH_TAGEXT: begin
                if (tag_ext_cnt_reg >= TAG_EXT_MAX || tag_acc_reg[27:21] != 7'd0) begin
                    r0_vld     = 1'b1;
                    r0.kind    = btlv_pkg::KIND_OVERSIZED;
                    phase_next = btlv_pkg::PH_TAG;
                end else begin
                    tag_ext_cnt_next = tag_ext_cnt_reg + TEW'(1);
                    tag_acc_next     = {tag_acc_reg[20:0], b[6:0]};
                    if (!b[7]) begin
                        phase_next = btlv_pkg::PH_LEN;
                    end
                end
            end
            btlv_pkg::PH_LEN: begin
                len_acc_next = '0;
                if (!b[7]) begin
                    len_acc_next = {24'd0, b};
                    do_hdr       = 1'b1;
                end else if (b[6:0] > LEN_CNT_MAX) begin
                    r0_vld     = 1'b1;
                    r0.kind    = btlv_pkg::KIND_OVERSIZED;
                    phase_next = btlv_pkg::PH_TAG;
                end else if (b[6:0] == 7'd0) begin
                    do_hdr = 1'b1;
                end else begin
                    len_left_next = b[LBW-1:0];
                    phase_next    = btlv_pkg::PH_LENEXT;
                end
            end
            btlv_pkg::PH_LENEXT: begin
                if (len_acc_reg[31:24] != 8'd0) begin
                    r0_vld     = 1'b1;
                    r0.kind    = btlv_pkg::KIND_OVERSIZED;
                    phase_next = btlv_pkg::PH_TAG;
                end else begin
                    len_acc_next  = {len_acc_reg[23:0], b};
                    len_left_next = len_left_dec;
                    if (len_left_dec == '0) begin
                        do_hdr = 1'b1;
                    end
                end
            end
            btlv_pkg::PH_VALUE: begin
                r0_vld        = 1'b1;
                r0.kind       = btlv_pkg::KIND_VALUE;
                r0.value_byte = b;
                r0.last_value = (val_left_reg == btlv_pkg::LEN_W'(1));
                val_left_next = val_left_dec;
                if (val_left_dec == '0) begin
                    phase_next = btlv_pkg::PH_TAG;
                end
            end
            default: begin
                phase_next = btlv_pkg::PH_TAG;
            end
        endcase

        if (do_hdr) begin
            r0_vld            = 1'b1;
            r0.kind           = btlv_pkg::KIND_HEADER;
            r0.first_tag_byte = held_tag_reg;
            r0.tag_number     = tag_acc_reg;
            r0.is_constructed = cons_reg;
            r0.value_length   = len_acc_next;
            if (cons_reg || len_acc_next == '0) begin
                phase_next = btlv_pkg::PH_TAG;
            end else begin
                val_left_next = len_acc_next;
                phase_next    = btlv_pkg::PH_VALUE;
            end
        end

        trunc = s_data.end_of_buffer && (phase_next != btlv_pkg::PH_TAG);
        if (trunc) begin
            phase_next = btlv_pkg::PH_TAG;
        end

        // first beat written is r0 if present, else the truncation beat
        beat_a          = r0_vld ? r0 : rt;
        beat_a.run_last = !(r0_vld && trunc);
        beat_b          = rt;
        beat_b.run_last = 1'b1;
        n_push          = {1'b0, r0_vld} + {1'b0, trunc};
    end

    always_comb begin
        count_next = count_reg;
        if (in_fire) begin
            count_next = count_next + CW'(n_push);
        end
        if (out_fire) begin
            count_next = count_next - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= btlv_pkg::PH_TAG;
            held_tag_reg    <= '0;
            tag_acc_reg     <= '0;
            tag_ext_cnt_reg <= '0;
            cons_reg        <= 1'b0;
            len_acc_reg     <= '0;
            len_left_reg    <= '0;
            val_left_reg    <= '0;
        end else if (in_fire) begin
            phase_reg       <= phase_next;
            held_tag_reg    <= held_tag_next;
            tag_acc_reg     <= tag_acc_next;
            tag_ext_cnt_reg <= tag_ext_cnt_next;
            cons_reg        <= cons_next;
            len_acc_reg     <= len_acc_next;
            len_left_reg    <= len_left_next;
            val_left_reg    <= val_left_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (in_fire) begin
                wr_ptr_reg <= wr_ptr_reg + PW'(n_push);
            end
            if (out_fire) begin
                rd_ptr_reg <= rd_ptr_reg + PW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire && n_push != 2'd0) begin
            fifo_reg[wr_ptr_reg] <= beat_a;
        end
        if (in_fire && n_push == 2'd2) begin
            fifo_reg[wr_ptr_reg + PW'(1)] <= beat_b;
        end
    end

    assign s_ready = (count_reg <= FILL_LIMIT);
    assign m_valid = (count_reg != '0);
    assign m_data  = fifo_reg[rd_ptr_reg];

endmodule
